### src/dreu_pkg.sv
// ----------------------------------------------------------------------------
// dreu_pkg: shared types, stage map and arithmetic steps for the ray angle unit
// Holds the in/out words, the pipeline record and the sqrt/divide step logic.
// ----------------------------------------------------------------------------
package dreu_pkg;

    localparam int NUM_CFG  = 6;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_B1X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B2X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B2Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B2Z = 3'd5;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // stage map
    localparam int ST_MUL  = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_SQ   = 2;
    localparam int ST_D2   = 3;
    localparam int ST_LZ   = 4;
    localparam int ST_NORM = 5;
    localparam int ST_RT1  = 6;    // 32 root stages
    localparam int ST_NUM  = 38;
    localparam int ST_DIV  = 39;   // 31 quotient stages
    localparam int ST_U    = 70;
    localparam int ST_DOT  = 71;
    localparam int ST_COS  = 72;
    localparam int ST_CSQ  = 73;
    localparam int ST_SIN2 = 74;
    localparam int ST_RT2  = 75;   // 32 root stages
    localparam int ST_OUT  = 107;
    localparam int ST_LAST = ST_OUT;

    typedef struct packed {
        logic [31:0] offset_a;
        logic [31:0] offset_b;
        logic [31:0] sight_x;
        logic [31:0] sight_y;
        logic [31:0] sight_z;
        logic [31:0] heading_x;
        logic [31:0] heading_y;
        logic [31:0] heading_z;
    } t_in_word;

    typedef struct packed {
        logic [31:0] unit_x;
        logic [31:0] unit_y;
        logic [31:0] unit_z;
        logic [63:0] dist_squared;
        logic [31:0] cos_angle;
        logic [30:0] cos_squared;
        logic [30:0] sin_squared;
        logic [30:0] sin_angle;
        logic        degenerate;
    } t_out_word;

    typedef struct packed {
        logic [31:0]        off_a;
        logic [31:0]        off_b;
        logic [2:0][31:0]   sight;
        logic [2:0][31:0]   heading;
        logic [2:0][63:0]   p1;
        logic [2:0][63:0]   p2;
        logic [2:0][31:0]   nv;
        logic [2:0][62:0]   sq;
        logic [2:0][31:0]   mag;
        logic [2:0]         neg;
        logic [63:0]        d2;
        logic               degen;
        logic [4:0]         k;
        logic [63:0]        sx;
        logic [34:0]        srem;
        logic [31:0]        sroot;
        logic [2:0][94:0]   num;
        logic [2:0][31:0]   drem;
        logic [2:0][30:0]   quo;
        logic [2:0][31:0]   unit;
        logic [2:0][63:0]   hp;
        logic [31:0]        cs;
        logic [61:0]        csq;
        logic [30:0]        s2;
        t_out_word          res;
    } t_pipe;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
    } t_sqrt_res;

    typedef struct packed {
        logic [31:0] rem;
        logic        qbit;
    } t_div_res;

    // one digit of the restoring square root
    function automatic t_sqrt_res sqrt_step(input logic [34:0] rem, input logic [31:0] root,
                                            input logic [1:0] pair);
        logic [34:0] r2;
        logic [34:0] t;
        t_sqrt_res   res;
        r2 = {rem[32:0], pair};
        t  = {1'b0, root, 2'b01};
        if (r2 >= t) begin
            res.rem  = r2 - t;
            res.root = {root[30:0], 1'b1};
        end else begin
            res.rem  = r2;
            res.root = {root[30:0], 1'b0};
        end
        return res;
    endfunction

    // one bit of the restoring divide
    function automatic t_div_res div_step(input logic [31:0] rem, input logic nbit,
                                          input logic [31:0] len);
        logic [32:0] r2;
        logic [32:0] d;
        t_div_res    res;
        r2 = {rem, nbit};
        d  = {1'b0, len};
        if (r2 >= d) begin
            d        = r2 - d;
            res.rem  = d[31:0];
            res.qbit = 1'b1;
        end else begin
            res.rem  = r2[31:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    // Q.30 rounding, halves up
    function automatic logic signed [35:0] round_q30(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = (p + 66'sd536870912) >>> 30;
        return t[35:0];
    endfunction

endpackage

### src/detector_ray_angle_eval_unit.sv
// ----------------------------------------------------------------------------
// detector_ray_angle_eval_unit: sight vector, length, unit vector and angle
// Fully pipelined evaluation of one detector sample point per clock unless the output stalls.
// ----------------------------------------------------------------------------
// An accepted word passes through every stage register in order, from capture to the output register.
// Throughput: one word per cycle while the output is not stalled; the 32-stage root and 31-stage divide
//   pipelines set the depth, not the rate.
// A stall on a valid output word freezes every stage together; nothing drops.
// Reset clears the valid bits and loads basis1 = (1,0,0), basis2 = (0,1,0).
module detector_ray_angle_eval_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dreu_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dreu_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [dreu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                       i_cfg_data
);
    import dreu_pkg::*;

    logic [NUM_CFG-1:0][31:0] r_basis;
    logic [ST_LAST:0]         r_vld;
    t_pipe                    r_st [0:ST_LAST];
    t_pipe                    n_st [0:ST_LAST];
    logic                     adv;

    // cos squared recomputed at the output from the held square
    function automatic logic [30:0] c2_of(input logic [61:0] q);
        logic [62:0] t;
        t = {1'b0, q} + 63'd536870912;
        return t[60:30];
    endfunction

    // advance whenever the output register is free or being taken
    assign adv         = !r_vld[ST_LAST] || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_out_valid = r_vld[ST_LAST];
    assign o_out_word  = r_st[ST_LAST].res;

    // basis registers; out-of-range indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // index 5 down to 0: b2z, b2y, b2x, b1z, b1y, b1x
            r_basis <= {32'd0, ONE_Q30, 32'd0, 32'd0, 32'd0, ONE_Q30};
        end else if (i_cfg_we && (i_cfg_idx <= CFG_B2Z)) begin
            r_basis[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[ST_LAST-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s <= ST_LAST; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Stage 0: capture the word and form the six basis products
    always_comb begin
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        logic signed [63:0] bb;
        n_st[ST_MUL]            = '0;
        n_st[ST_MUL].off_a      = i_in_word.offset_a;
        n_st[ST_MUL].off_b      = i_in_word.offset_b;
        n_st[ST_MUL].sight[0]   = i_in_word.sight_x;
        n_st[ST_MUL].sight[1]   = i_in_word.sight_y;
        n_st[ST_MUL].sight[2]   = i_in_word.sight_z;
        n_st[ST_MUL].heading[0] = i_in_word.heading_x;
        n_st[ST_MUL].heading[1] = i_in_word.heading_y;
        n_st[ST_MUL].heading[2] = i_in_word.heading_z;
        ea = 64'($signed(i_in_word.offset_a));
        eb = 64'($signed(i_in_word.offset_b));
        for (int i = 0; i < 3; i++) begin
            bb = 64'($signed(r_basis[i]));
            n_st[ST_MUL].p1[i] = ea * bb;
            bb = 64'($signed(r_basis[i+3]));
            n_st[ST_MUL].p2[i] = eb * bb;
        end
    end

    for (genvar s = 1; s <= ST_LAST; s++) begin : g_stage
        // digit positions for the root and divide stages
        localparam int RJ1 = (s >= ST_RT1 && s < ST_RT1 + 32) ? ST_RT1 + 31 - s : 0;
        localparam int RJ2 = (s >= ST_RT2 && s < ST_RT2 + 32) ? ST_RT2 + 31 - s : 0;
        localparam int DJ  = (s >= ST_DIV && s < ST_DIV + 31) ? ST_DIV + 30 - s : 0;

        always_comb begin
            logic signed [35:0] acc;
            logic signed [63:0] a64;
            logic signed [63:0] b64;
            logic signed [65:0] dot;
            logic [62:0]        csr;
            logic [30:0]        c2;
            logic [5:0]         lz;
            logic [63:0]        v;
            t_sqrt_res          sr;
            t_div_res           dr;
            t_pipe              p;
            p   = r_st[s-1];
            acc = '0;
            a64 = '0;
            b64 = '0;
            dot = '0;
            csr = '0;
            c2  = '0;
            lz  = '0;
            v   = '0;
            sr  = '0;
            dr  = '0;
            if (s == ST_SUM) begin
                // sight plus rounded products, saturate to 32 bits
                for (int i = 0; i < 3; i++) begin
                    acc = 36'($signed(p.sight[i])) + round_q30(66'($signed(p.p1[i])))
                        + round_q30(66'($signed(p.p2[i])));
                    if (acc > 36'sh0_7FFF_FFFF) begin
                        p.nv[i] = 32'h7FFF_FFFF;
                    end else if (acc < -36'sh0_8000_0000) begin
                        p.nv[i] = 32'h8000_0000;
                    end else begin
                        p.nv[i] = acc[31:0];
                    end
                end
            end else if (s == ST_SQ) begin
                for (int i = 0; i < 3; i++) begin
                    a64      = 64'($signed(p.nv[i]));
                    a64      = a64 * a64;
                    p.sq[i]  = a64[62:0];
                    p.neg[i] = p.nv[i][31];
                    p.mag[i] = p.nv[i][31] ? (~p.nv[i] + 32'd1) : p.nv[i];
                end
            end else if (s == ST_D2) begin
                p.d2 = {1'b0, p.sq[0]} + {1'b0, p.sq[1]} + {1'b0, p.sq[2]};
            end else if (s == ST_LZ) begin
                // leading-zero search in six halving steps
                v = p.d2;
                if (v[63:32] == '0) begin lz = lz + 6'd32; v = v << 32; end
                if (v[63:48] == '0) begin lz = lz + 6'd16; v = v << 16; end
                if (v[63:56] == '0) begin lz = lz + 6'd8;  v = v << 8;  end
                if (v[63:60] == '0) begin lz = lz + 6'd4;  v = v << 4;  end
                if (v[63:62] == '0) begin lz = lz + 6'd2;  v = v << 2;  end
                if (v[63] == 1'b0)  begin lz = lz + 6'd1;               end
                p.k     = lz[5:1];
                p.degen = (p.d2 == '0);
            end else if (s == ST_NORM) begin
                p.sx    = p.d2 << {p.k, 1'b0};
                p.srem  = '0;
                p.sroot = '0;
            end else if ((s >= ST_RT1 && s < ST_RT1 + 32) || (s >= ST_RT2 && s < ST_RT2 + 32)) begin
                if (s < ST_RT2) begin
                    sr = sqrt_step(p.srem, p.sroot, p.sx[2*RJ1 +: 2]);
                end else begin
                    sr = sqrt_step(p.srem, p.sroot, p.sx[2*RJ2 +: 2]);
                end
                p.srem  = sr.rem;
                p.sroot = sr.root;
            end else if (s == ST_NUM) begin
                // numerator with half the divisor added for rounding
                for (int i = 0; i < 3; i++) begin
                    p.num[i]  = (95'(p.mag[i]) << (7'd30 + 7'(p.k))) + 95'(p.sroot >> 1);
                    p.drem[i] = p.num[i][62:31];
                    p.quo[i]  = '0;
                end
            end else if (s >= ST_DIV && s < ST_DIV + 31) begin
                for (int i = 0; i < 3; i++) begin
                    dr            = div_step(p.drem[i], p.num[i][DJ], p.sroot);
                    p.drem[i]     = dr.rem;
                    p.quo[i][DJ]  = dr.qbit;
                end
            end else if (s == ST_U) begin
                for (int i = 0; i < 3; i++) begin
                    p.unit[i] = p.neg[i] ? (~{1'b0, p.quo[i]} + 32'd1) : {1'b0, p.quo[i]};
                end
            end else if (s == ST_DOT) begin
                for (int i = 0; i < 3; i++) begin
                    a64     = 64'($signed(p.heading[i]));
                    b64     = 64'($signed(p.unit[i]));
                    p.hp[i] = a64 * b64;
                end
            end else if (s == ST_COS) begin
                // negate the rounded dot, clamp to [-1.0, 1.0]
                dot = 66'($signed(p.hp[0])) + 66'($signed(p.hp[1])) + 66'($signed(p.hp[2]));
                acc = -round_q30(dot);
                if (acc > 36'sh0_4000_0000) begin
                    p.cs = ONE_Q30;
                end else if (acc < -36'sh0_4000_0000) begin
                    p.cs = ~ONE_Q30 + 32'd1;
                end else begin
                    p.cs = acc[31:0];
                end
            end else if (s == ST_CSQ) begin
                a64   = 64'($signed(p.cs));
                a64   = a64 * a64;
                p.csq = a64[61:0];
            end else if (s == ST_SIN2) begin
                csr     = {1'b0, p.csq} + 63'd536870912;
                c2      = csr[60:30];
                p.s2    = (c2 > ONE_Q30[30:0]) ? '0 : (ONE_Q30[30:0] - c2);
                p.sx    = {3'b000, p.s2, 30'd0};
                p.srem  = '0;
                p.sroot = '0;
            end else if (s == ST_OUT) begin
                // zero everything for a null sight vector
                if (p.degen) begin
                    p.res            = '0;
                    p.res.degenerate = 1'b1;
                end else begin
                    p.res.unit_x       = p.unit[0];
                    p.res.unit_y       = p.unit[1];
                    p.res.unit_z       = p.unit[2];
                    p.res.dist_squared = p.d2;
                    p.res.cos_angle    = p.cs;
                    p.res.cos_squared  = c2_of(p.csq);
                    p.res.sin_squared  = p.s2;
                    p.res.sin_angle    = p.sroot[30:0];
                    p.res.degenerate   = 1'b0;
                end
            end
            n_st[s] = p;
        end
    end

endmodule

### src/dreu_chk.sv
// ----------------------------------------------------------------------------
// dreu_chk: port-level checks for the ray angle unit
// Watches the output word over time; bound to the top level below.
// ----------------------------------------------------------------------------
module dreu_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  dreu_pkg::t_out_word               o_out_word
);
    import dreu_pkg::*;

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.degenerate |->
            o_out_word.unit_x == '0 && o_out_word.unit_y == '0 && o_out_word.unit_z == '0 &&
            o_out_word.dist_squared == '0 && o_out_word.cos_angle == '0 &&
            o_out_word.sin_angle == '0 && o_out_word.sin_squared == '0)
        else $error("degenerate word carries nonzero fields");

    a_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.degenerate |-> o_out_word.dist_squared != '0)
        else $error("zero length without degenerate flag");

    a_pythag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.degenerate |->
            32'(o_out_word.sin_squared) + 32'(o_out_word.cos_squared) == ONE_Q30)
        else $error("sin^2 + cos^2 differs from one");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_out_word.cos_angle) <= $signed(ONE_Q30) &&
                        $signed(o_out_word.cos_angle) >= -$signed(ONE_Q30))
        else $error("cosine out of range");

endmodule

bind detector_ray_angle_eval_unit dreu_chk u_dreu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the detector ray angle unit
// Drives sample points through the pipeline under several stall patterns and
// basis settings, and checks every output word against a built-in predictor or a fixed row.
// ----------------------------------------------------------------------------
module tb_top;
    import dreu_pkg::*;

    localparam int LATENCY   = 107;
    localparam int MAX_CYC   = 600000;
    localparam int N_RANDOM  = 1400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;
    logic      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    detector_ray_angle_eval_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the basis registers
    logic signed [31:0] basis1 [3];
    logic signed [31:0] basis2 [3];

    t_out_word expected_q [$];
    int  n_fail = 0;
    int  cyc = 0;
    int  send_idle_pct = 0;   // sender idle chance, percent
    int  recv_stall_pct = 0;  // receiver stall chance, percent
    int  hold_off = 0;        // long receiver hold-off, in cycles
    int  hold_cnt = 0;        // hold-off cycles already spent

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] rem, root, b;
        rem = x; root = 0; b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // round a Q.60-scaled product to Q.30 units, halves up (arithmetic shift floors)
    function automatic logic signed [127:0] rnd30(input logic signed [127:0] p);
        return (p + 128'sd536870912) >>> 30;
    endfunction

    function automatic t_out_word predict_ray(input t_in_word w);
        t_out_word r;
        logic signed [127:0] c, dot, cs, c2, s2;
        logic signed [31:0] nv [3];
        logic signed [31:0] hv [3];
        logic signed [31:0] uv [3];
        logic [63:0] d2, len, mag;
        logic [127:0] q;
        int lz, k;
        r = '0;
        hv[0] = w.heading_x; hv[1] = w.heading_y; hv[2] = w.heading_z;
        d2 = 0;
        for (int i = 0; i < 3; i++) begin
            c = (i == 0 ? $signed(w.sight_x) : i == 1 ? $signed(w.sight_y) : $signed(w.sight_z));
            c = c + rnd30($signed(w.offset_a) * basis1[i])
                  + rnd30($signed(w.offset_b) * basis2[i]);
            if (c < -128'sd2147483648) c = -128'sd2147483648;
            if (c > 128'sd2147483647) c = 128'sd2147483647;
            nv[i] = c[31:0];
            d2 = d2 + 64'(longint'(nv[i]) * longint'(nv[i]));
        end
        if (d2 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        lz = 0;
        while (d2[63 - lz] == 1'b0) lz++;
        k = lz / 2;
        len = floor_sqrt(d2 << (2 * k));
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            mag = nv[i] < 0 ? 64'(-longint'(nv[i])) : 64'(nv[i]);
            q = ((128'(mag) << (30 + k)) + 128'(len / 2)) / 128'(len);
            uv[i] = nv[i] < 0 ? -$signed(q[31:0]) : $signed(q[31:0]);
            dot = dot + hv[i] * uv[i];
        end
        cs = -rnd30(dot);
        if (cs < -128'sd1073741824) cs = -128'sd1073741824;
        if (cs > 128'sd1073741824) cs = 128'sd1073741824;
        c2 = (cs * cs + 128'sd536870912) >>> 30;
        s2 = 128'sd1073741824 - c2;
        if (s2 < 0) s2 = 0;
        r.unit_x = uv[0]; r.unit_y = uv[1]; r.unit_z = uv[2];
        r.dist_squared = d2;
        r.cos_angle = cs[31:0];
        r.cos_squared = c2[30:0];
        r.sin_squared = s2[30:0];
        r.sin_angle = 31'(floor_sqrt(64'(s2) << 30));
        return r;
    endfunction

    // Directed rows: fixed expectations only where obvious.
    typedef struct {
        t_in_word  w;
        bit        fixed;
        t_out_word res;
    } t_row;
    t_row rows [$];

    function automatic t_in_word mk(input logic [31:0] a, b, sx, sy, sz, hx, hy, hz);
        t_in_word w;
        w = '{a, b, sx, sy, sz, hx, hy, hz};
        return w;
    endfunction

    function automatic t_out_word degen_word();
        t_out_word r;
        r = '0;
        r.degenerate = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hc000_0000;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after acceptance; the next idle cycle or drain drops it
    task automatic send_word(input t_in_word w, input bit fixed, input t_out_word res);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        // record on acceptance
        expected_q.push_back(fixed ? res : predict_ray(w));
    endtask

    // write enable stays high; the caller drops it after the last write
    task automatic write_basis(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        if (idx < 3) basis1[idx] = v; else basis2[idx - 3] = v;
    endtask

    // drain the pipe before touching the basis registers
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        t_in_word w;
        for (int i = 0; i < n; i++) begin
            w = '{rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
                  rand_field(), rand_field(), rand_field()};
            // keep offsets small most of the time so saturation stays occasional
            if ($urandom_range(0, 3) != 0) begin
                w.offset_a = 32'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'h3ff_ffff);
                w.offset_b = 32'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'h3ff_ffff);
            end
            if (i % 50 == 0) begin
                w.sight_x = 0; w.sight_y = 0; w.sight_z = 0;
                if (i % 100 == 0) begin w.offset_a = 0; w.offset_b = 0; end
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off != 0 && hold_cnt < hold_off) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_out_stall <= recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct;
        end
    end

    // Output checker: compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("output word with nothing expected");
                n_fail++;
            end else begin
                e = expected_q.pop_front();
                if (o_out_word.unit_x !== e.unit_x) begin
                    $error("unit_x exp %h got %h", e.unit_x, o_out_word.unit_x); n_fail++; end
                if (o_out_word.unit_y !== e.unit_y) begin
                    $error("unit_y exp %h got %h", e.unit_y, o_out_word.unit_y); n_fail++; end
                if (o_out_word.unit_z !== e.unit_z) begin
                    $error("unit_z exp %h got %h", e.unit_z, o_out_word.unit_z); n_fail++; end
                if (o_out_word.dist_squared !== e.dist_squared) begin
                    $error("dist_squared exp %h got %h", e.dist_squared,
                           o_out_word.dist_squared); n_fail++; end
                if (o_out_word.cos_angle !== e.cos_angle) begin
                    $error("cos_angle exp %h got %h", e.cos_angle, o_out_word.cos_angle);
                    n_fail++; end
                if (o_out_word.cos_squared !== e.cos_squared) begin
                    $error("cos_squared exp %h got %h", e.cos_squared,
                           o_out_word.cos_squared); n_fail++; end
                if (o_out_word.sin_squared !== e.sin_squared) begin
                    $error("sin_squared exp %h got %h", e.sin_squared,
                           o_out_word.sin_squared); n_fail++; end
                if (o_out_word.sin_angle !== e.sin_angle) begin
                    $error("sin_angle exp %h got %h", e.sin_angle, o_out_word.sin_angle);
                    n_fail++; end
                if (o_out_word.degenerate !== e.degenerate) begin
                    $error("degenerate exp %b got %b", e.degenerate, o_out_word.degenerate);
                    n_fail++; end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= MAX_CYC) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_out_word along_x, along_y;
        basis1 = '{32'h4000_0000, 0, 0};
        basis2 = '{0, 32'h4000_0000, 0};

        // Directed rows. Unit length along an axis with head-on heading gives
        // cos 1.0, sin 0; zero sight is degenerate.
        along_x = '0;
        along_x.unit_x = ONE_Q30;
        along_x.dist_squared = 64'h1_0000_0000;
        along_x.cos_angle = ONE_Q30;
        along_x.cos_squared = ONE_Q30;
        along_y = '0;
        along_y.unit_y = ONE_Q30;
        along_y.dist_squared = 64'h1_0000_0000;
        along_y.sin_squared = ONE_Q30;
        along_y.sin_angle = ONE_Q30;
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, degen_word()});
        rows.push_back('{mk(0, 0, 0, 0, 0, ONE_Q30, 0, 0), 1, degen_word()});
        rows.push_back('{mk(0, 0, 32'h1_0000, 0, 0, 32'hc000_0000, 0, 0), 1, along_x});
        rows.push_back('{mk(0, 0, 0, 32'h1_0000, 0, ONE_Q30, 0, 0), 1, along_y});
        // offsets alone cancel the sight vector
        rows.push_back('{mk(32'h1_0000, 32'hffff_0000, 32'hffff_0000, 32'h1_0000, 0,
                            0, 0, 0), 1, degen_word()});
        rows.push_back('{mk(32'h1_0000, 0, 0, 0, 0, 32'hc000_0000, 0, 0), 1, along_x});
        // extremes and saturation
        rows.push_back('{mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, '0});
        rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, '0});
        rows.push_back('{mk(32'h7fff_ffff, 32'h8000_0000, 1, 0, 32'hffff_ffff,
                            0, 32'h8000_0000, 32'h7fff_ffff), 0, '0});
        rows.push_back('{mk(0, 0, 1, 0, 0, 32'h4000_0000, 0, 0), 0, '0});
        rows.push_back('{mk(0, 0, 0, 0, 32'hffff_ffff, 0, 0, 32'h4000_0000), 0, '0});
        rows.push_back('{mk(0, 0, 32'h3_0000, 32'h4_0000, 0, 32'h2666_6666, 32'h3333_3333, 0),
                        0, '0});
        rows.push_back('{mk(0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, '0});
        rows.push_back('{mk(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                            32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa), 0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].res);
        drain();

        // Basis settings: identity, extremes, random, tilted, then back to identity.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off = 400; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            case (phase)
                1: for (int r = 0; r < NUM_CFG; r++)
                       write_basis(CFG_IDX_W'(r), 32'h8000_0000);
                2: for (int r = 0; r < NUM_CFG; r++)
                       write_basis(CFG_IDX_W'(r), 32'h7fff_ffff);
                3: for (int r = 0; r < NUM_CFG; r++)
                       write_basis(CFG_IDX_W'(r), $urandom);
                4: begin
                    write_basis(CFG_B1X, 32'h2d41_3ccd); write_basis(CFG_B1Y, 0);
                    write_basis(CFG_B1Z, 32'hd2be_c333); write_basis(CFG_B2X, 0);
                    write_basis(CFG_B2Y, 32'hc000_0000); write_basis(CFG_B2Z, 0);
                end
                5: begin
                    write_basis(CFG_B1X, ONE_Q30); write_basis(CFG_B1Y, 0);
                    write_basis(CFG_B1Z, 0);       write_basis(CFG_B2X, 0);
                    write_basis(CFG_B2Y, ONE_Q30); write_basis(CFG_B2Z, 0);
                end
                default: ;
            endcase
            i_cfg_we <= 1'b0;
            run_random(N_RANDOM / 6);
            drain();
        end

        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (expected_q.size() != 0)
                $error("%0d expected words never arrived", expected_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
